// ===== rtl/core/lfmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfmc_pkg
// Shared widths, register indexes, result codes and FSM type for the
// LRU/FIFO cache miss classifier.
// ----------------------------------------------------------------------------
package lfmc_pkg;

  // fixed stream field widths
  localparam int IN_ADDR_W   = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int CNT_W       = 32;
  localparam int OUT_TDATA_W = 3 * CNT_W;
  localparam int OUT_TUSER_W = 3;
  localparam int CAP_W       = 5;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd1;

  localparam logic             POLICY_LRU  = 1'b0;
  localparam logic             POLICY_FIFO = 1'b1;
  localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;

  // miss_kind codes
  localparam logic [1:0] KIND_HIT        = 2'd0;
  localparam logic [1:0] KIND_COMPULSORY = 2'd1;
  localparam logic [1:0] KIND_CAPACITY   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DROP,
    ST_DONE
  } state_t;

  // saturating +1
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ===== rtl/core/lru_fifo_cache_miss_classifier.sv =====
// ----------------------------------------------------------------------------
// lru_fifo_cache_miss_classifier
// Fully associative cache simulator: each input word is one access address;
// each output word reports hit/miss, the miss class and three saturating
// running totals. After reset the block runs a clearing pass over every
// entry of the seen-address map and takes no input word meanwhile; config
// writes are taken at all times. An access then passes through an accept
// state, a scan that compares one resident entry at a time through a single
// shared comparator (stopping at the first match, or after every resident
// entry on a miss), on a FIFO miss a drop phase that sheds entries from the
// front until the list is back within capacity (a full list sheds its
// oldest entry on the append at no extra cost), and an output-load state
// that waits while a held result blocks the output register. The entry scan
// through the one comparator sets the rate. One access is in flight at a
// time; a finished result waits in the output register while the next word
// is taken.
// ----------------------------------------------------------------------------
module lru_fifo_cache_miss_classifier #(
  parameter int WAYS      = 16,
  parameter int ADDR_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream; in_tdata: [11:0] access_address
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lfmc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream; out_tdata: [31:0] access_total, [63:32] compulsory_total,
  // [95:64] capacity_total
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lfmc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] is_hit, [2:1] miss_kind
  output logic [lfmc_pkg::OUT_TUSER_W-1:0] out_tuser,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lfmc_pkg::*;

  localparam int IW    = (WAYS > 1) ? $clog2(WAYS) : 1;   // entry index
  localparam int CW    = $clog2(WAYS + 1);                // entry count
  localparam int XW    = (ADDR_BITS > IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
  localparam int DEPTH = 1 << ADDR_BITS;

  state_t                 state_r, state_nxt;
  logic                   policy_r;
  logic [CAP_W-1:0]       cap_r;
  logic [ADDR_BITS-1:0]   ent_r [0:WAYS-1];
  logic [ADDR_BITS-1:0]   ent_nxt [0:WAYS-1];
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [ADDR_BITS-1:0]   addr_r, addr_nxt;
  logic [ADDR_BITS-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       comp_r, comp_nxt;
  logic [CNT_W-1:0]       capc_r, capc_nxt;
  logic                   hit_r, hit_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // seen-address map
  logic                   seen_mem [0:DEPTH-1];
  logic                   seen_q_r;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_wa;
  logic                   mem_wd;
  logic                   rd_en;

  logic [XW-1:0]          in_addr_ext;
  logic [ADDR_BITS-1:0]   in_addr;
  logic [CW-1:0]          cap_eff;
  logic [CW:0]            fill_inc;

  assign in_addr_ext = XW'(in_tdata[IN_ADDR_W-1:0]);
  assign in_addr     = in_addr_ext[ADDR_BITS-1:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // capacity of 0 acts as 1, above WAYS as WAYS
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > 32'(WAYS)) begin
      cap_eff = CW'(WAYS);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  assign fill_inc = {1'b0, fill_r} + {{CW{1'b0}}, 1'b1};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_LRU;
      cap_r    <= CAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POLICY_MODE: policy_r <= cfg_data[0];
        REG_CAPACITY:    cap_r    <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // seen map: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      seen_q_r <= seen_mem[in_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      fill_r      <= '0;
      acc_r       <= '0;
      comp_r      <= '0;
      capc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fill_r      <= fill_nxt;
      acc_r       <= acc_nxt;
      comp_r      <= comp_nxt;
      capc_r      <= capc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    idx_r       <= idx_nxt;
    addr_r      <= addr_nxt;
    hit_r       <= hit_nxt;
    kind_r      <= kind_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    clr_nxt       = clr_r;
    acc_nxt       = acc_r;
    comp_nxt      = comp_r;
    capc_nxt      = capc_r;
    hit_nxt       = hit_r;
    kind_nxt      = kind_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = addr_r;
    mem_wd        = 1'b0;
    rd_en         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + {{(ADDR_BITS-1){1'b0}}, 1'b1};
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          rd_en     = 1'b1;
          addr_nxt  = in_addr;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (idx_r >= fill_r) begin
          // miss: classify from the seen map, mark it seen
          acc_nxt = sat_inc(acc_r);
          hit_nxt = 1'b0;
          mem_we  = 1'b1;
          mem_wd  = 1'b1;
          if (seen_q_r) begin
            kind_nxt = KIND_CAPACITY;
            capc_nxt = sat_inc(capc_r);
          end else begin
            kind_nxt = KIND_COMPULSORY;
            comp_nxt = sat_inc(comp_r);
          end
          if (policy_r == POLICY_LRU) begin
            // insert at front, tail beyond capacity falls off
            for (int i = 1; i < WAYS; i++) begin
              ent_nxt[i] = ent_r[i-1];
            end
            ent_nxt[0] = addr_r;
            fill_nxt   = (fill_inc > {1'b0, cap_eff}) ? cap_eff : fill_inc[CW-1:0];
            state_nxt  = ST_DONE;
          end else begin
            // append at the tail; full list drops its oldest right here
            if (fill_r == CW'(WAYS)) begin
              for (int i = 0; i < WAYS - 1; i++) begin
                ent_nxt[i] = ent_r[i+1];
              end
              ent_nxt[WAYS-1] = addr_r;
            end else begin
              ent_nxt[fill_r[IW-1:0]] = addr_r;
              fill_nxt                = fill_inc[CW-1:0];
            end
            state_nxt = ST_DROP;
          end
        end else if (ent_r[idx_r[IW-1:0]] == addr_r) begin
          acc_nxt  = sat_inc(acc_r);
          hit_nxt  = 1'b1;
          kind_nxt = KIND_HIT;
          if (policy_r == POLICY_LRU) begin
            // move to front
            for (int i = 1; i < WAYS; i++) begin
              if (CW'(i) <= idx_r) begin
                ent_nxt[i] = ent_r[i-1];
              end
            end
            ent_nxt[0] = addr_r;
          end
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + {{(CW-1){1'b0}}, 1'b1};
        end
      end

      ST_DROP: begin
        // FIFO: drop oldest entries until within capacity
        if (fill_r > cap_eff) begin
          for (int i = 0; i < WAYS - 1; i++) begin
            ent_nxt[i] = ent_r[i+1];
          end
          fill_nxt = fill_r - {{(CW-1){1'b0}}, 1'b1};
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_tdata_nxt = {capc_r, comp_r, acc_r};
          out_tuser_nxt = {kind_r, hit_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // a hit carries kind HIT, a miss never does
  a_kind_vs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tuser_r[0] == (out_tuser_r[2:1] == KIND_HIT)))
    else $error("is_hit and miss_kind disagree");

  // an accepted word starts a scan on the next cycle
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");

  // nothing is reported while the seen map is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result valid during clearing pass");

  // drop phase only follows an append, so the list is never empty there
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DROP) |-> (fill_r != '0))
    else $error("drop phase with empty list");
`endif

endmodule

// ===== dv/tb_lru_fifo_cache_miss_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_fifo_cache_miss_classifier
// Streams access addresses into the cache miss classifier and checks every
// result word against an in-bench LRU/FIFO cache model, over a series of
// policy and capacity settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_lru_fifo_cache_miss_classifier;
  import lfmc_pkg::*;

  localparam int WAYS       = 16;
  localparam int ADDR_BITS  = 12;
  localparam int PHASES     = 11;
  localparam int PHASE_LEN  = 148;
  localparam int HOLD_AFTER = 400;   // words taken before the long receiver hold
  localparam int HOLD_LEN   = 250;
  localparam int END_SETTLE = 40;    // > one full miss scan plus output load
  localparam int TIMEOUT_NS = 2_000_000;

  // indexes past the two registers; the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic             is_hit;
    logic [1:0]       kind;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] compulsory_total;
    logic [CNT_W-1:0] capacity_total;
  } access_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  lru_fifo_cache_miss_classifier #(
    .WAYS     (WAYS),
    .ADDR_BITS(ADDR_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- cache model
  logic [ADDR_BITS-1:0] resident_q[$];    // LRU: MRU first; FIFO: oldest first
  bit                   seen_addr[1 << ADDR_BITS];
  logic [CNT_W-1:0]     n_access = '0;
  logic [CNT_W-1:0]     n_compulsory = '0;
  logic [CNT_W-1:0]     n_capacity = '0;
  logic                 policy_q = POLICY_LRU;
  logic [CAP_W-1:0]     cap_q = CAP_RESET;

  access_result_t       pending_results[$];
  logic [ADDR_BITS-1:0] addr_backlog[$];
  logic [ADDR_BITS-1:0] history[$];       // recent addresses, for capacity misses
  int                   words_taken = 0;
  int                   mismatch_count = 0;
  bit                   calm_tail = 1'b0;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // 0 acts as 1, anything above WAYS acts as WAYS
  function automatic int cap_limit();
    int c;
    c = cap_q;
    if (c < 1) c = 1;
    if (c > WAYS) c = WAYS;
    return c;
  endfunction

  function automatic access_result_t classify_access(input logic [ADDR_BITS-1:0] a);
    access_result_t r;
    int hit_at;
    hit_at = -1;
    foreach (resident_q[i])
      if (hit_at < 0 && resident_q[i] == a) hit_at = i;
    n_access = count_up(n_access);
    r.is_hit = (hit_at >= 0);
    r.kind   = KIND_HIT;
    if (hit_at >= 0) begin
      if (policy_q == POLICY_LRU) begin
        resident_q.delete(hit_at);
        resident_q.push_front(a);
      end
    end else begin
      // a miss also trims any surplus left by a lowered capacity
      if (policy_q == POLICY_LRU) begin
        resident_q.push_front(a);
        while (resident_q.size() > cap_limit()) resident_q.delete(resident_q.size() - 1);
      end else begin
        resident_q.insert(resident_q.size(), a);
        while (resident_q.size() > cap_limit()) void'(resident_q.pop_front());
      end
      if (!seen_addr[a]) begin
        seen_addr[a] = 1'b1;
        n_compulsory = count_up(n_compulsory);
        r.kind = KIND_COMPULSORY;
      end else begin
        n_capacity = count_up(n_capacity);
        r.kind = KIND_CAPACITY;
      end
    end
    r.access_total     = n_access;
    r.compulsory_total = n_compulsory;
    r.capacity_total   = n_capacity;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  int tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.insert(pending_results.size(),
                               classify_access(in_tdata[ADDR_BITS-1:0]));
        words_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (addr_backlog.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(addr_backlog.pop_front());
          if (!calm_tail && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  // one long hold lets the result register and the input side back up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && words_taken >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic tally_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: MISMATCH %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_hit           = out_tuser[0];
      got.kind             = out_tuser[2:1];
      got.access_total     = out_tdata[CNT_W-1:0];
      got.compulsory_total = out_tdata[2*CNT_W-1:CNT_W];
      got.capacity_total   = out_tdata[3*CNT_W-1:2*CNT_W];
      if (pending_results.size() == 0) begin
        tally_mismatch($sformatf("result word with nothing expected, access_total %0d",
                                 got.access_total));
      end else begin
        want = pending_results.pop_front();
        if (got.is_hit != want.is_hit)
          tally_mismatch($sformatf("is_hit exp %0d got %0d", want.is_hit, got.is_hit));
        if (got.kind != want.kind)
          tally_mismatch($sformatf("miss_kind exp %0d got %0d", want.kind, got.kind));
        if (got.access_total != want.access_total)
          tally_mismatch($sformatf("access_total exp %0d got %0d",
                                   want.access_total, got.access_total));
        if (got.compulsory_total != want.compulsory_total)
          tally_mismatch($sformatf("compulsory_total exp %0d got %0d",
                                   want.compulsory_total, got.compulsory_total));
        if (got.capacity_total != want.capacity_total)
          tally_mismatch($sformatf("capacity_total exp %0d got %0d",
                                   want.capacity_total, got.capacity_total));
      end
    end
  end

  // ---------------------------------------------------------------- sequencing
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // register taken at this edge
    if (idx == REG_POLICY_MODE) policy_q = val[0];
    else if (idx == REG_CAPACITY) cap_q = val[CAP_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // queue one address word for the driver
  task automatic enqueue_addr(input logic [ADDR_BITS-1:0] a);
    addr_backlog.insert(addr_backlog.size(), a);
  endtask

  // sender holds off until every word is back and the block is idle
  task automatic wait_drained();
    @(negedge clk);
    while (addr_backlog.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  // working set sized around the capacity, with drift, recalls and strays
  task automatic gen_phase(input int count);
    logic [ADDR_BITS-1:0] hot[$];
    logic [ADDR_BITS-1:0] a;
    int ws;
    int roll;
    ws = cap_limit() - 2 + $urandom_range(0, 4);
    if (ws < 1) ws = 1;
    repeat (ws) hot.insert(hot.size(), ADDR_BITS'($urandom()));
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        a = hot[$urandom_range(0, ws - 1)];
      end else if (roll < 85 && history.size() > 0) begin
        a = history[$urandom_range(0, history.size() - 1)];
      end else if (roll < 93) begin
        a = ADDR_BITS'($urandom());
      end else begin
        a = ADDR_BITS'($urandom());
        hot[$urandom_range(0, ws - 1)] = a;
      end
      enqueue_addr(a);
      history.insert(history.size(), a);
      if (history.size() > 256) void'(history.pop_front());
    end
  endtask

  initial begin
    logic             pol_plan[PHASES];
    logic [CAP_W-1:0] cap_plan[PHASES];
    pol_plan = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU,
                 POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                 POLICY_LRU};
    cap_plan = '{5'd16, 5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd5, 5'd0, 5'd0, 5'd0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: upper data bits must be dropped, spare indexes ignored
    write_reg(REG_POLICY_MODE, 8'hFE);
    write_reg(REG_CAPACITY, 8'hF0);
    write_reg(REG_SPARE_LO, 8'h01);
    write_reg(REG_SPARE_HI, 8'hFF);
    // address extremes, first touches and plain hits
    enqueue_addr(12'h000); enqueue_addr(12'hFFF);
    enqueue_addr(12'h000); enqueue_addr(12'hFFF);
    enqueue_addr(12'h555); enqueue_addr(12'hAAA);
    enqueue_addr(12'h555);
    wait_drained();

    // lowered capacity with four entries resident, LRU evictions
    write_reg(REG_CAPACITY, 8'd2);
    enqueue_addr(12'h001); enqueue_addr(12'h002);
    enqueue_addr(12'h001); enqueue_addr(12'h003);
    enqueue_addr(12'h002); enqueue_addr(12'h000);
    wait_drained();

    // capacity zero acts as one; FIFO
    write_reg(REG_POLICY_MODE, 8'h01);
    write_reg(REG_CAPACITY, 8'd0);
    enqueue_addr(12'h7FF); enqueue_addr(12'h7FF);
    enqueue_addr(12'h800); enqueue_addr(12'h7FF);
    wait_drained();

    // capacity above WAYS, then cut while resident: surplus hits, trim on miss
    write_reg(REG_CAPACITY, 8'd31);
    enqueue_addr(12'h100); enqueue_addr(12'h101);
    enqueue_addr(12'h102); enqueue_addr(12'h103);
    wait_drained();
    write_reg(REG_CAPACITY, 8'd2);
    enqueue_addr(12'h100); enqueue_addr(12'h104);
    enqueue_addr(12'h102); enqueue_addr(12'h103);
    wait_drained();

    // random phases; the list survives each policy/capacity change
    for (int p = 0; p < PHASES; p++) begin
      if (p >= 8) begin
        pol_plan[p] = 1'($urandom_range(0, 1));
        cap_plan[p] = CAP_W'($urandom_range(0, 31));
      end
      if (p == PHASES - 1) calm_tail = 1'b1;
      write_reg(REG_POLICY_MODE, {7'($urandom()), pol_plan[p]});
      write_reg(REG_CAPACITY, {3'($urandom()), cap_plan[p]});
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom()));
      gen_phase(PHASE_LEN);
      wait_drained();
    end

    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
